// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the detector modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define GLM_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define GLM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GLM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/glm_pkg.sv -----
`default_nettype none

package glm_pkg;

    // Default sizing of the grid and the stored value width
    localparam int DEF_MAX_COLS   = 1024;
    localparam int DEF_MAX_ROWS   = 1024;
    localparam int DEF_VALUE_BITS = 16;

    // Fixed field widths of the channels
    localparam int CFG_DATA_BITS  = 11;
    localparam int IN_VALUE_BITS  = 16;
    localparam int OUT_VALUE_BITS = 16;
    localparam int INDEX_BITS     = 10;
    localparam int COUNT_BITS     = 21;

    typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;
    typedef logic [IN_VALUE_BITS-1:0]  in_value_t;
    typedef logic [OUT_VALUE_BITS-1:0] out_value_t;
    typedef logic [INDEX_BITS-1:0]     index_t;
    typedef logic [COUNT_BITS-1:0]     count_t;

    localparam cfg_data_t RST_NUM_ROWS = cfg_data_t'(16);
    localparam cfg_data_t RST_NUM_COLS = cfg_data_t'(16);

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_NUM_ROWS = 1'b0,
        CFG_NUM_COLS = 1'b1
    } cfg_index_t;

    // Input word
    typedef struct packed {
        in_value_t cell_value;
        logic      is_pad;
    } in_word_t;

    // Result word
    typedef struct packed {
        out_value_t center_value;
        index_t     row_index;
        index_t     col_index;
        logic       bright;
        count_t     bright_total;
        logic       grid_done;
    } out_word_t;

    // Position status of an accepted word, carried down the pipeline
    typedef struct packed {
        logic emit;
        logic has_up;
        logic has_dn;
        logic has_lf;
        logic has_rt;
        logic done;
    } pos_flags_t;

endpackage

`default_nettype wire

// ----- hw/rtl/grid_local_maximum_detector.sv -----
// 3x3 local maximum detector over a raster-order grid stream.
// Channels: item (valid/ready) takes one grid value per word in raster
// order; result (valid/ready) returns one word per grid cell with its value,
// row, column, bright flag, running bright count and a last-cell flag.
// cfg (valid/ready, always ready) writes num_rows or num_cols; the user must write them
// while idle, as the block does not enforce it; any write restarts the grid.
// After the last grid value send num_cols+1 pad words to drain the last row.
// The first num_cols+1 words of a grid give no result; after that each word
// gives the result for the cell num_cols+1 words earlier, passing through the
// read stage, the window stage and the output word register.
// Throughput: one word per cycle while the result receiver keeps up. Each word
// does one read and one write-back of the shared line store memory, pipelined with a one-deep forward.
// Reset clears counters, window and count and sets both sizes to 16; the
// line store is not cleared, its unwritten entries only feed missing
// neighbours. A stalled result receiver freezes the whole pipeline and
// item_ready drops until the result word is taken.
`default_nettype none

module grid_local_maximum_detector #(
    parameter int MAX_COLS   = glm_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS   = glm_pkg::DEF_MAX_ROWS,
    parameter int VALUE_BITS = glm_pkg::DEF_VALUE_BITS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire glm_pkg::in_word_t   item,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output glm_pkg::out_word_t       result,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire glm_pkg::cfg_index_t cfg_index,
    input  wire glm_pkg::cfg_data_t  cfg_data
);

    localparam int CW  = $clog2(MAX_COLS);
    localparam int CNW = $clog2(MAX_COLS+2);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int RNW = $clog2(MAX_ROWS+1);

    glm_pkg::cfg_data_t    num_rows_reg;
    glm_pkg::cfg_data_t    num_cols_reg;
    logic [RNW-1:0]        rows;
    logic [CNW-1:0]        cols;
    logic                  adv;
    logic                  accept;
    logic                  cfg_write;
    logic [VALUE_BITS-1:0] in_value;
    logic [CW-1:0]         rd_addr;
    glm_pkg::pos_flags_t   flags;
    logic [RW-1:0]         out_row;
    logic [CW-1:0]         out_col;
    logic [VALUE_BITS-1:0] rd_upper;
    logic [VALUE_BITS-1:0] rd_middle;

    logic                  s1_valid_reg;
    logic [VALUE_BITS-1:0] s1_value_reg;
    logic [CW-1:0]         s1_addr_reg;
    glm_pkg::pos_flags_t   s1_flags_reg;
    logic [RW-1:0]         s1_row_reg;
    logic [CW-1:0]         s1_col_reg;

    // Handshakes: the pipeline moves whenever the output slot frees
    assign adv        = !result_valid || result_ready;
    assign item_ready = adv;
    assign accept     = item_valid && item_ready;
    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;

    // Pad words enter as zero
    assign in_value = item.is_pad ? '0 : VALUE_BITS'(item.cell_value);

    // Clamp sizes to 1..maximum
    always_comb
    begin
        if (num_rows_reg == '0)
        begin
            rows = RNW'(1);
        end
        else if (32'(num_rows_reg) > MAX_ROWS)
        begin
            rows = RNW'(MAX_ROWS);
        end
        else
        begin
            rows = RNW'(num_rows_reg);
        end
        if (num_cols_reg == '0)
        begin
            cols = CNW'(1);
        end
        else if (32'(num_cols_reg) > MAX_COLS)
        begin
            cols = CNW'(MAX_COLS);
        end
        else
        begin
            cols = CNW'(num_cols_reg);
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= glm_pkg::RST_NUM_ROWS;
            num_cols_reg <= glm_pkg::RST_NUM_COLS;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                glm_pkg::CFG_NUM_ROWS: num_rows_reg <= cfg_data;
                glm_pkg::CFG_NUM_COLS: num_cols_reg <= cfg_data;
                default:               num_rows_reg <= num_rows_reg;
            endcase
        end
    end

    glm_pos_ctrl #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_pos_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .restart (cfg_write),
        .cols    (cols),
        .rows    (rows),
        .rd_addr (rd_addr),
        .flags   (flags),
        .out_row (out_row),
        .out_col (out_col)
    );

    // Read stage: word waits here for its line store data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_value_reg <= in_value;
            s1_addr_reg  <= rd_addr;
            s1_flags_reg <= flags;
            s1_row_reg   <= out_row;
            s1_col_reg   <= out_col;
        end
    end

    // Line stores: push middle up, new value into middle
    glm_line_store #(
        .DEPTH (MAX_COLS),
        .WIDTH (VALUE_BITS)
    ) u_line_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr   (rd_addr),
        .wr_en     (adv && s1_valid_reg),
        .wr_addr   (s1_addr_reg),
        .wr_upper  (rd_middle),
        .wr_middle (s1_value_reg),
        .rd_upper  (rd_upper),
        .rd_middle (rd_middle)
    );

    glm_window #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .VALUE_BITS (VALUE_BITS)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .restart      (cfg_write),
        .s1_valid     (s1_valid_reg),
        .s1_value     (s1_value_reg),
        .s1_upper     (rd_upper),
        .s1_middle    (rd_middle),
        .s1_flags     (s1_flags_reg),
        .s1_row       (s1_row_reg),
        .s1_col       (s1_col_reg),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/glm_line_store.sv -----
`default_nettype none

`include "assert_macros.svh"

module glm_line_store #(
    parameter int DEPTH = glm_pkg::DEF_MAX_COLS,
    parameter int WIDTH = glm_pkg::DEF_VALUE_BITS
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_upper,
    input  wire logic [WIDTH-1:0]         wr_middle,
    output logic      [WIDTH-1:0]         rd_upper,
    output logic      [WIDTH-1:0]         rd_middle
);

    // Upper line in the high half, middle line in the low half
    logic [2*WIDTH-1:0] mem [DEPTH];
    logic [2*WIDTH-1:0] rd_q_reg;
    logic [2*WIDTH-1:0] fwd_data_reg;
    logic               fwd_reg;

    // Write back, and read into a register
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_upper, wr_middle};
        end
        if (rd_en)
        begin
            rd_q_reg     <= mem[rd_addr];
            fwd_data_reg <= {wr_upper, wr_middle};
        end
    end

    // Flag a read that collides with the write of the same edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    // Take the forwarded word over the stale memory word
    assign rd_upper  = fwd_reg ? fwd_data_reg[2*WIDTH-1:WIDTH] : rd_q_reg[2*WIDTH-1:WIDTH];
    assign rd_middle = fwd_reg ? fwd_data_reg[WIDTH-1:0] : rd_q_reg[WIDTH-1:0];

    `GLM_ASSERT_NEXT(a_fwd_upper, clk, rst_n, rd_en && wr_en && (rd_addr == wr_addr), rd_upper === $past(wr_upper), "line store read missed a colliding write")

endmodule

`default_nettype wire

// ----- hw/rtl/glm_pos_ctrl.sv -----
`default_nettype none

`include "assert_macros.svh"

module glm_pos_ctrl #(
    parameter int MAX_COLS = glm_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = glm_pkg::DEF_MAX_ROWS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic                          restart,
    input  wire logic [$clog2(MAX_COLS+2)-1:0] cols,
    input  wire logic [$clog2(MAX_ROWS+1)-1:0] rows,
    output logic      [$clog2(MAX_COLS)-1:0]   rd_addr,
    output glm_pkg::pos_flags_t                flags,
    output logic      [$clog2(MAX_ROWS)-1:0]   out_row,
    output logic      [$clog2(MAX_COLS)-1:0]   out_col
);

    localparam int CW  = $clog2(MAX_COLS);
    localparam int CNW = $clog2(MAX_COLS+2);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int RNW = $clog2(MAX_ROWS+1);

    logic [CW-1:0]  in_col_reg, in_col_next;
    logic [CNW-1:0] in_pos_reg;
    logic [RW-1:0]  out_row_reg;
    logic [CW-1:0]  out_col_reg;
    logic [CW-1:0]  col_now;
    logic [CNW-1:0] col_plus;
    logic [CNW-1:0] cols_p1;

    // Column of the line stores for this word, and the next one
    always_comb
    begin
        col_now     = (CNW'(in_col_reg) < cols) ? in_col_reg : '0;
        col_plus    = CNW'(col_now) + CNW'(1);
        in_col_next = (col_plus >= cols) ? '0 : CW'(col_plus);
        cols_p1     = cols + CNW'(1);
    end

    // Neighbour presence of the cell the next result describes
    always_comb
    begin
        flags.emit   = (in_pos_reg >= cols_p1);
        flags.has_up = (out_row_reg != '0);
        flags.has_dn = ((RNW'(out_row_reg) + RNW'(1)) < rows);
        flags.has_lf = (out_col_reg != '0);
        flags.has_rt = ((CNW'(out_col_reg) + CNW'(1)) < cols);
        flags.done   = !flags.has_dn && !flags.has_rt;
    end

    assign rd_addr = col_now;
    assign out_row = out_row_reg;
    assign out_col = out_col_reg;

    // Advance fill count and output position per accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_pos_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
        end
        else if (restart)
        begin
            in_col_reg  <= '0;
            in_pos_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
        end
        else if (accept)
        begin
            if (!flags.emit)
            begin
                in_col_reg <= in_col_next;
                in_pos_reg <= in_pos_reg + CNW'(1);
            end
            else if (flags.done)
            begin
                in_col_reg  <= '0;
                in_pos_reg  <= '0;
                out_row_reg <= '0;
                out_col_reg <= '0;
            end
            else
            begin
                in_col_reg <= in_col_next;
                if (!flags.has_rt)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + RW'(1);
                end
                else
                begin
                    out_col_reg <= out_col_reg + CW'(1);
                end
            end
        end
    end

    `GLM_ASSERT_ALWAYS(a_fill_bound, clk, rst_n, in_pos_reg <= cols_p1, "fill count ran past the window depth")
    `GLM_ASSERT_NEXT(a_grid_wrap, clk, rst_n, accept && flags.emit && flags.done, (in_pos_reg == '0) && (out_row_reg == '0) && (out_col_reg == '0), "grid did not restart after its last cell")

endmodule

`default_nettype wire

// ----- hw/rtl/glm_window.sv -----
`default_nettype none

`include "assert_macros.svh"

module glm_window #(
    parameter int MAX_COLS   = glm_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS   = glm_pkg::DEF_MAX_ROWS,
    parameter int VALUE_BITS = glm_pkg::DEF_VALUE_BITS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        adv,
    input  wire logic                        restart,
    input  wire logic                        s1_valid,
    input  wire logic [VALUE_BITS-1:0]       s1_value,
    input  wire logic [VALUE_BITS-1:0]       s1_upper,
    input  wire logic [VALUE_BITS-1:0]       s1_middle,
    input  wire glm_pkg::pos_flags_t         s1_flags,
    input  wire logic [$clog2(MAX_ROWS)-1:0] s1_row,
    input  wire logic [$clog2(MAX_COLS)-1:0] s1_col,
    output logic                             result_valid,
    output glm_pkg::out_word_t               result
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);

    logic [VALUE_BITS-1:0] win_reg [9];
    logic [VALUE_BITS-1:0] win_next [9];
    logic                  s2_valid_reg;
    glm_pkg::pos_flags_t   s2_flags_reg;
    logic [RW-1:0]         s2_row_reg;
    logic [CW-1:0]         s2_col_reg;
    logic                  result_valid_reg;
    glm_pkg::out_word_t    result_reg;
    glm_pkg::count_t       bright_cnt_reg;
    glm_pkg::count_t       total;
    logic                  bright;

    // Shift the window left and bring in the new right column
    always_comb
    begin
        win_next = win_reg;
        for (int r = 0; r < 3; r++)
        begin
            win_next[r*3]   = win_reg[r*3+1];
            win_next[r*3+1] = win_reg[r*3+2];
        end
        win_next[2] = s1_upper;
        win_next[5] = s1_middle;
        win_next[8] = s1_value;
    end

    // Compare the centre against every neighbour that exists
    always_comb
    begin
        logic present;
        bright = 1'b1;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                present = !((r == 1) && (c == 1));
                if ((r == 0) && !s2_flags_reg.has_up) present = 1'b0;
                if ((r == 2) && !s2_flags_reg.has_dn) present = 1'b0;
                if ((c == 0) && !s2_flags_reg.has_lf) present = 1'b0;
                if ((c == 2) && !s2_flags_reg.has_rt) present = 1'b0;
                if (present && !(win_reg[4] > win_reg[r*3+c]))
                begin
                    bright = 1'b0;
                end
            end
        end
        total = bright_cnt_reg + glm_pkg::count_t'(bright);
    end

    // Hold the window and the compare stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (s1_valid)
            begin
                win_reg <= win_next;
            end
            s2_valid_reg <= s1_valid && s1_flags.emit;
        end
    end

    // Stage metadata alongside the window
    always_ff @(posedge clk)
    begin
        if (adv && s1_valid)
        begin
            s2_flags_reg <= s1_flags;
            s2_row_reg   <= s1_row;
            s2_col_reg   <= s1_col;
        end
    end

    // Output word register and running bright count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            bright_cnt_reg   <= '0;
        end
        else
        begin
            if (adv)
            begin
                result_valid_reg <= s2_valid_reg;
            end
            if (restart)
            begin
                bright_cnt_reg <= '0;
            end
            else if (adv && s2_valid_reg)
            begin
                bright_cnt_reg <= s2_flags_reg.done ? '0 : total;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s2_valid_reg)
        begin
            result_reg.center_value <= glm_pkg::out_value_t'(win_reg[4]);
            result_reg.row_index    <= glm_pkg::index_t'(s2_row_reg);
            result_reg.col_index    <= glm_pkg::index_t'(s2_col_reg);
            result_reg.bright       <= bright;
            result_reg.bright_total <= total;
            result_reg.grid_done    <= s2_flags_reg.done;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `GLM_ASSERT_NEXT(a_count_clear, clk, rst_n, adv && s2_valid_reg && s2_flags_reg.done, bright_cnt_reg == '0, "bright count not cleared after last cell")

endmodule

`default_nettype wire

// ----- tb/grid_local_maximum_detector_checker.sv -----
`timescale 1ns / 1ps

module grid_local_maximum_detector_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_ready,
    input  glm_pkg::in_word_t   item,
    input  logic                result_valid,
    input  logic                result_ready,
    input  glm_pkg::out_word_t  result,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  glm_pkg::cfg_index_t cfg_index,
    input  glm_pkg::cfg_data_t  cfg_data,
    output int                  fail_count,
    output int                  pending
);

    localparam int GRID_MAX_COLS = glm_pkg::DEF_MAX_COLS;
    localparam int GRID_MAX_ROWS = glm_pkg::DEF_MAX_ROWS;
    localparam int REPORT_LIMIT  = 10;

    // Line stores, 3x3 window and grid position of the predicted block
    glm_pkg::in_value_t upper_store [GRID_MAX_COLS];
    glm_pkg::in_value_t middle_store [GRID_MAX_COLS];
    glm_pkg::in_value_t window [9];
    glm_pkg::cfg_data_t rows_reg;
    glm_pkg::cfg_data_t cols_reg;
    int unsigned        fill_count;
    int unsigned        in_col;
    int unsigned        out_row;
    int unsigned        out_col;
    glm_pkg::count_t    bright_count;

    // Result words still owed by the block, oldest first
    glm_pkg::out_word_t expected_words [$];
    glm_pkg::out_word_t oldest;
    int                 failures;
    int                 idx;

    task automatic restart_grid();
        fill_count   = 0;
        in_col       = 0;
        out_row      = 0;
        out_col      = 0;
        bright_count = '0;
    endtask

    // Advance the window by one word and queue the result it completes, if any
    task automatic predict_local_max(input glm_pkg::in_word_t w);
        int unsigned        rows;
        int unsigned        cols;
        int unsigned        c;
        int                 r;
        int                 k;
        glm_pkg::in_value_t v;
        glm_pkg::in_value_t centre;
        logic               has_up;
        logic               has_dn;
        logic               has_lf;
        logic               has_rt;
        logic               is_bright;
        logic               exists;
        logic               last_cell;
        glm_pkg::out_word_t exp_word;

        rows = (rows_reg == 0) ? 1 : ((rows_reg > GRID_MAX_ROWS) ? GRID_MAX_ROWS : rows_reg);
        cols = (cols_reg == 0) ? 1 : ((cols_reg > GRID_MAX_COLS) ? GRID_MAX_COLS : cols_reg);
        v = w.is_pad ? '0 : w.cell_value;
        c = (in_col < cols) ? in_col : 0;

        // shift left, load the new column on the right
        for (r = 0; r < 3; r++) begin
            window[r * 3]     = window[r * 3 + 1];
            window[r * 3 + 1] = window[r * 3 + 2];
        end
        window[2]       = upper_store[c];
        window[5]       = middle_store[c];
        window[8]       = v;
        upper_store[c]  = middle_store[c];
        middle_store[c] = v;
        in_col = (c + 1 >= cols) ? 0 : c + 1;

        // the first num_cols+1 words of a grid only fill the pipeline
        if (fill_count < cols + 1) begin
            fill_count++;
        end
        else begin
            centre = window[4];
            has_up = out_row > 0;
            has_dn = out_row + 1 < rows;
            has_lf = out_col > 0;
            has_rt = out_col + 1 < cols;

            // compare only against neighbours that lie inside the grid
            is_bright = 1'b1;
            for (k = 0; k < 9; k++) begin
                exists = (k != 4);
                if (k / 3 == 0 && !has_up)
                    exists = 1'b0;
                if (k / 3 == 2 && !has_dn)
                    exists = 1'b0;
                if (k % 3 == 0 && !has_lf)
                    exists = 1'b0;
                if (k % 3 == 2 && !has_rt)
                    exists = 1'b0;
                if (exists && !(centre > window[k]))
                    is_bright = 1'b0;
            end
            bright_count = bright_count + is_bright;
            last_cell = (out_row + 1 >= rows) && (out_col + 1 >= cols);

            exp_word.center_value = centre;
            exp_word.row_index    = glm_pkg::index_t'(out_row);
            exp_word.col_index    = glm_pkg::index_t'(out_col);
            exp_word.bright       = is_bright;
            exp_word.bright_total = bright_count;
            exp_word.grid_done    = last_cell;
            expected_words.push_back(exp_word);

            if (last_cell) begin
                restart_grid();
            end
            else if (out_col + 1 >= cols) begin
                out_col = 0;
                out_row++;
            end
            else begin
                out_col++;
            end
        end
    endtask

    // Watch the three channels; predict on accepted items, compare accepted results
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rows_reg = glm_pkg::RST_NUM_ROWS;
            cols_reg = glm_pkg::RST_NUM_COLS;
            for (idx = 0; idx < GRID_MAX_COLS; idx++) begin
                upper_store[idx]  = '0;
                middle_store[idx] = '0;
            end
            for (idx = 0; idx < 9; idx++)
                window[idx] = '0;
            restart_grid();
            expected_words.delete();
            failures = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == glm_pkg::CFG_NUM_ROWS)
                    rows_reg = cfg_data;
                else
                    cols_reg = cfg_data;
                restart_grid();
            end

            if (item_valid && item_ready)
                predict_local_max(item);

            if (result_valid && result_ready) begin
                if (expected_words.size() == 0) begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("unexpected result word: value=%h row=%0d col=%0d bright=%b",
                                 result.center_value, result.row_index, result.col_index,
                                 result.bright);
                end
                else begin
                    oldest = expected_words.pop_front();
                    if (result.center_value !== oldest.center_value ||
                        result.row_index    !== oldest.row_index    ||
                        result.col_index    !== oldest.col_index    ||
                        result.bright       !== oldest.bright       ||
                        result.bright_total !== oldest.bright_total ||
                        result.grid_done    !== oldest.grid_done) begin
                        failures++;
                        if (failures <= REPORT_LIMIT) begin
                            $display("expected value=%h row=%0d col=%0d bright=%b total=%0d done=%b",
                                     oldest.center_value, oldest.row_index, oldest.col_index,
                                     oldest.bright, oldest.bright_total, oldest.grid_done);
                            $display("  actual value=%h row=%0d col=%0d bright=%b total=%0d done=%b",
                                     result.center_value, result.row_index, result.col_index,
                                     result.bright, result.bright_total, result.grid_done);
                        end
                    end
                end
            end

            fail_count <= failures;
            pending    <= expected_words.size();
        end
    end

endmodule

// ----- tb/grid_local_maximum_detector_tb.sv -----
`timescale 1ns / 1ps

module grid_local_maximum_detector_tb;

    localparam int RANDOM_WORDS  = 600;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 2000;

    typedef enum int {
        FILL_RANDOM,
        FILL_LOW,
        FILL_HIGH,
        FILL_EXTREMES
    } fill_t;

    typedef enum int {
        DRAIN_CLEAN,
        DRAIN_REAL,
        DRAIN_SHORT,
        DRAIN_EXTRA
    } drain_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_ready;
    glm_pkg::in_word_t   item         = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    glm_pkg::out_word_t  result;
    logic                cfg_valid    = 1'b0;
    logic                cfg_ready;
    glm_pkg::cfg_index_t cfg_index    = glm_pkg::CFG_NUM_ROWS;
    glm_pkg::cfg_data_t  cfg_data     = '0;

    int   fail_count;
    int   pending;
    int   words_sent  = 0;
    int   idle_cycles = 0;
    int   ready_left  = 0;
    logic steady      = 1'b0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    grid_local_maximum_detector u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    grid_local_maximum_detector_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // Throttle the result side: bursts of acceptance, short stalls, now and then a long one
    always @(posedge clk) begin
        if (steady) begin
            result_ready <= 1'b1;
            ready_left   <= 0;
        end
        else if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end
        else if ($urandom_range(0, 1) == 0) begin
            result_ready <= 1'b1;
            ready_left   <= $urandom_range(0, 15);
        end
        else begin
            result_ready <= 1'b0;
            ready_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(0, 3);
        end
    end

    // Drop the run when no channel has moved a word for too long
    always @(posedge clk) begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("grid_local_maximum_detector: mismatch");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic glm_pkg::in_value_t pick_value(input fill_t fill);
        case (fill)
            FILL_RANDOM: return glm_pkg::in_value_t'($urandom_range(0, 65535));
            FILL_LOW:    return glm_pkg::in_value_t'($urandom_range(0, 3));
            FILL_HIGH:   return glm_pkg::in_value_t'($urandom_range(65532, 65535));
            default:     return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
        endcase
    endfunction

    // Offer one word after a random gap and hold it until accepted
    task automatic send_word(input glm_pkg::in_value_t value, input logic pad);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= {value, pad};
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        words_sent++;
    endtask

    // Hold the sender until every owed result has arrived and the pipeline is empty
    task automatic wait_for_idle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_grid_size(input glm_pkg::cfg_data_t rows_raw,
                                 input glm_pkg::cfg_data_t cols_raw);
        wait_for_idle();
        cfg_valid <= 1'b1;
        cfg_index <= glm_pkg::CFG_NUM_ROWS;
        cfg_data  <= rows_raw;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= glm_pkg::CFG_NUM_COLS;
        cfg_data  <= cols_raw;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Send one grid in raster order followed by its drain words
    task automatic send_grid(input int rows, input int cols, input fill_t fill,
                             input drain_t drain, input int hold_at);
        int   cells;
        int   drain_words;
        int   i;
        logic pad;
        cells       = rows * cols;
        drain_words = cols + 1;
        if (drain == DRAIN_SHORT)
            drain_words = drain_words - $urandom_range(1, cols);
        if (drain == DRAIN_EXTRA)
            drain_words++;
        for (i = 0; i < cells; i++) begin
            if (i == hold_at)
                wait_for_idle();
            // a rare pad inside the grid acts as a zero cell
            pad = (fill == FILL_RANDOM) && ($urandom_range(0, 39) == 0);
            send_word(pick_value(fill), pad);
        end
        for (i = 0; i < drain_words; i++) begin
            if (drain == DRAIN_REAL && $urandom_range(0, 1) == 0)
                send_word(glm_pkg::in_value_t'($urandom_range(0, 65535)), 1'b0);
            else
                send_word(glm_pkg::in_value_t'($urandom_range(0, 65535)), 1'b1);
        end
    endtask

    initial begin
        int     rows;
        int     cols;
        int     grids;
        int     g;
        int     roll;
        int     directed_words;
        int     hold_at;
        drain_t drain;
        glm_pkg::cfg_data_t rows_raw;
        glm_pkg::cfg_data_t cols_raw;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Single cell: no neighbours, so it is bright; first drain word carries a real value
        set_grid_size(1, 1);
        send_word(16'hFFFF, 1'b0);
        send_word(16'h1234, 1'b0);
        send_word(16'hBEEF, 1'b1);

        // 3x3 with every corner a local maximum; a pad stands in for the zero cell
        set_grid_size(3, 3);
        send_word(16'hFFFF, 1'b0);
        send_word(16'd1, 1'b0);
        send_word(16'd8, 1'b0);
        send_word(16'd2, 1'b0);
        send_word(16'd3, 1'b0);
        wait_for_idle();
        send_word(16'd4, 1'b0);
        send_word(16'd7, 1'b0);
        send_word(16'hFFFF, 1'b1);
        send_word(16'd6, 1'b0);
        repeat (4) send_word(16'h0000, 1'b1);

        // Zero sizes count as one
        set_grid_size(0, 0);
        send_word(16'h0000, 1'b0);
        repeat (2) send_word(16'h0000, 1'b1);

        // Abandon a grid part way, then a flat 2x2 where ties leave nothing bright
        set_grid_size(2, 2);
        send_word(16'h0055, 1'b0);
        send_word(16'h00AA, 1'b0);
        set_grid_size(2, 2);
        repeat (4) send_word(16'h0005, 1'b0);
        repeat (3) send_word(16'h0000, 1'b1);

        directed_words = words_sent;

        // Random phases over small grids
        while (words_sent < directed_words + RANDOM_WORDS) begin
            rows     = $urandom_range(1, 6);
            cols     = $urandom_range(1, 8);
            rows_raw = glm_pkg::cfg_data_t'(rows);
            cols_raw = glm_pkg::cfg_data_t'(cols);
            if (rows == 1 && $urandom_range(0, 1) == 0)
                rows_raw = '0;
            if (cols == 1 && $urandom_range(0, 1) == 0)
                cols_raw = '0;
            set_grid_size(rows_raw, cols_raw);
            steady = ($urandom_range(0, 3) == 0);
            grids  = $urandom_range(1, 3);
            for (g = 0; g < grids; g++) begin
                roll = $urandom_range(0, 99);
                if (roll < 60)
                    drain = DRAIN_CLEAN;
                else if (roll < 85)
                    drain = DRAIN_REAL;
                else if (roll < 93)
                    drain = DRAIN_SHORT;
                else
                    drain = DRAIN_EXTRA;
                hold_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, rows * cols - 1) : -1;
                send_grid(rows, cols, fill_t'($urandom_range(0, 3)), drain, hold_at);
            end
        end

        // Register values above the limit clamp; a short partial grid only fills
        steady = 1'b0;
        set_grid_size(2047, 2047);
        repeat (30) send_word(glm_pkg::in_value_t'($urandom_range(0, 65535)), 1'b0);

        // Wider grid with the receiver never stalling
        steady = 1'b1;
        set_grid_size(3, 40);
        send_grid(3, 40, FILL_RANDOM, DRAIN_CLEAN, -1);
        steady = 1'b0;

        wait_for_idle();
        if (fail_count == 0)
            $display("grid_local_maximum_detector: match");
        else
            $display("grid_local_maximum_detector: mismatch");
        $finish;
    end

endmodule
